>>> rtl/njr_pkg.sv
// ----------------------------------------------------------------------------
// njr_pkg
// shared types, codes and reset values of the network join retry controller
// ----------------------------------------------------------------------------
package njr_pkg;

    // failure count saturation default
    localparam int unsigned MAX_FAILURES_DEF = 5;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_4  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_5  = 3'd5;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_RST   = 16'd240;
    localparam logic [31:0] BACKOFF_1_RST = 32'd1800;
    localparam logic [31:0] BACKOFF_2_RST = 32'd3600;
    localparam logic [31:0] BACKOFF_3_RST = 32'd7200;
    localparam logic [31:0] BACKOFF_4_RST = 32'd28800;
    localparam logic [31:0] BACKOFF_5_RST = 32'd86400;

    // phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_INIT   = 3'd1;
    localparam logic [2:0] PH_REG    = 3'd2;
    localparam logic [2:0] PH_JOINED = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    // awake hold codes
    localparam logic [1:0] HOLD_NONE    = 2'd0;
    localparam logic [1:0] HOLD_JOIN    = 2'd1;
    localparam logic [1:0] HOLD_DEFAULT = 2'd2;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic        busy_pin;
        logic        stat_pin;
        logic        link_lost;
    } njr_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        joined_flag;
        logic        net_error;
        logic        modem_restart;
        logic        status_query;
        logic        sleep_request;
        logic        sync_request;
        logic [1:0]  awake_hold;
        logic [2:0]  fail_count;
        logic [31:0] reconnect_time;
    } njr_result_t;

    typedef struct packed {
        logic [15:0] timeout;
        logic [31:0] backoff_first;
        logic [31:0] backoff_second;
        logic [31:0] backoff_third;
        logic [31:0] backoff_fourth;
        logic [31:0] backoff_fifth;
    } njr_cfg_t;

endpackage

>>> rtl/njr_poll_if.sv
// ----------------------------------------------------------------------------
// njr_poll_if
// poll tick channel: time and modem pin levels
// ----------------------------------------------------------------------------
interface njr_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_seconds;
    logic        busy_pin;
    logic        stat_pin;
    logic        link_lost;

    modport source (
        output valid, now_seconds, busy_pin, stat_pin, link_lost,
        input  ready
    );
    modport sink (
        input  valid, now_seconds, busy_pin, stat_pin, link_lost,
        output ready
    );
endinterface

>>> rtl/njr_report_if.sv
// ----------------------------------------------------------------------------
// njr_report_if
// per-tick report channel: phase, flags, command pulses, backoff state
// ----------------------------------------------------------------------------
interface njr_report_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic        joined_flag;
    logic        net_error;
    logic        modem_restart;
    logic        status_query;
    logic        sleep_request;
    logic        sync_request;
    logic [1:0]  awake_hold;
    logic [2:0]  fail_count;
    logic [31:0] reconnect_time;

    modport source (
        output valid, phase, joined_flag, net_error, modem_restart, status_query,
               sleep_request, sync_request, awake_hold, fail_count, reconnect_time,
        input  ready
    );
    modport sink (
        input  valid, phase, joined_flag, net_error, modem_restart, status_query,
               sleep_request, sync_request, awake_hold, fail_count, reconnect_time,
        output ready
    );
endinterface

>>> rtl/njr_cfg_if.sv
// ----------------------------------------------------------------------------
// njr_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface njr_cfg_if;
    import njr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/network_join_retry_controller.sv
// ----------------------------------------------------------------------------
// network_join_retry_controller
// modem join sequencer with register-wait timeout and failure backoff
// ----------------------------------------------------------------------------
//  channel  dir  transfer moves
//  -------  ---  --------------------------------------------------------
//  poll     in   one poll tick: now_seconds, busy_pin, stat_pin, link_lost
//  report   out  one report per tick: phase, flags, pulses, fail count, time
//  cfg      in   one register write: index, data (always ready)
//
//  a tick is taken into the input register, stepped through the sequencer
//  once the report register is free or being drained, and lands in that
//  register; one tick per cycle unless report stalls, set by the single pass
//  through the sequencer. a stalled report holds the report register; one
//  more tick may wait in the input register before poll ready drops
//  reset loads sequencer and config reset values and clears both valid bits
// ----------------------------------------------------------------------------
module network_join_retry_controller #(
    parameter int unsigned MAX_FAILURES = njr_pkg::MAX_FAILURES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    njr_poll_if.sink  poll,
    njr_report_if.source report,
    njr_cfg_if.sink   cfg
);
    import njr_pkg::*;

    // input register
    logic        in_valid_reg;
    njr_item_t   in_item_reg;

    // report register
    logic        out_valid_reg;
    njr_result_t out_result_reg;

    njr_cfg_t    regs;
    njr_result_t step_result;
    logic        advance;

    // step the held tick when the report register is free or being drained
    assign advance    = in_valid_reg && (!out_valid_reg || report.ready);
    assign poll.ready = !in_valid_reg || advance;

    njr_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    njr_sequencer #(
        .MAX_FAILURES (MAX_FAILURES)
    ) u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .regs   (regs),
        .result (step_result)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.ready)
            begin
                in_valid_reg <= poll.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            in_item_reg.now_seconds <= poll.now_seconds;
            in_item_reg.busy_pin    <= poll.busy_pin;
            in_item_reg.stat_pin    <= poll.stat_pin;
            in_item_reg.link_lost   <= poll.link_lost;
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.phase          = out_result_reg.phase;
    assign report.joined_flag    = out_result_reg.joined_flag;
    assign report.net_error      = out_result_reg.net_error;
    assign report.modem_restart  = out_result_reg.modem_restart;
    assign report.status_query   = out_result_reg.status_query;
    assign report.sleep_request  = out_result_reg.sleep_request;
    assign report.sync_request   = out_result_reg.sync_request;
    assign report.awake_hold     = out_result_reg.awake_hold;
    assign report.fail_count     = out_result_reg.fail_count;
    assign report.reconnect_time = out_result_reg.reconnect_time;

    // a stepped tick always shows up as a report in the next cycle
    a_step_reports: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped tick did not reach the report register");

    // poll may only stall while a tick is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !poll.ready |-> in_valid_reg)
        else $error("poll stalled with an empty input register");

    // a modem restart pulse is issued only on the way into register wait
    a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && report.modem_restart) |-> (report.phase == PH_REG))
        else $error("restart pulse outside register wait entry");

    // failure count never passes its saturation value
    a_fail_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (report.fail_count <= 3'(MAX_FAILURES)))
        else $error("failure count above saturation");

endmodule

>>> rtl/njr_cfg_regs.sv
// ----------------------------------------------------------------------------
// njr_cfg_regs
// timeout and backoff delay registers behind the write channel
// ----------------------------------------------------------------------------
module njr_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    njr_cfg_if.sink         cfg,
    output njr_pkg::njr_cfg_t regs
);
    import njr_pkg::*;

    njr_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.timeout        <= TIMEOUT_RST;
            regs_reg.backoff_first  <= BACKOFF_1_RST;
            regs_reg.backoff_second <= BACKOFF_2_RST;
            regs_reg.backoff_third  <= BACKOFF_3_RST;
            regs_reg.backoff_fourth <= BACKOFF_4_RST;
            regs_reg.backoff_fifth  <= BACKOFF_5_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_TIMEOUT:   regs_reg.timeout        <= cfg.data[15:0];
                CFG_BACKOFF_1: regs_reg.backoff_first  <= cfg.data;
                CFG_BACKOFF_2: regs_reg.backoff_second <= cfg.data;
                CFG_BACKOFF_3: regs_reg.backoff_third  <= cfg.data;
                CFG_BACKOFF_4: regs_reg.backoff_fourth <= cfg.data;
                CFG_BACKOFF_5: regs_reg.backoff_fifth  <= cfg.data;
                default:       ; // unmapped index, write dropped
            endcase
        end
    end

endmodule

>>> rtl/njr_sequencer.sv
// ----------------------------------------------------------------------------
// njr_sequencer
// join phase sequencer with wait counter, failure count and backoff time
// ----------------------------------------------------------------------------
module njr_sequencer #(
    parameter int unsigned MAX_FAILURES = njr_pkg::MAX_FAILURES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  njr_pkg::njr_item_t   item,
    input  njr_pkg::njr_cfg_t    regs,
    output njr_pkg::njr_result_t result
);
    import njr_pkg::*;

    typedef enum logic [2:0] {
        IDLE   = PH_IDLE,
        INIT   = PH_INIT,
        REG    = PH_REG,
        JOINED = PH_JOINED,
        ERROR  = PH_ERROR
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic        lse_reg,    lse_next;
    logic        joined_reg, joined_next;
    logic [15:0] wait_reg,   wait_next;
    logic [2:0]  fail_reg,   fail_next;
    logic [31:0] nat_reg,    nat_next;

    logic        due;
    logic [15:0] wait_inc;
    logic [2:0]  fail_sat;
    logic [31:0] delay;

    assign due      = (nat_reg <= item.now_seconds);
    assign wait_inc = 16'(wait_reg + 16'd1);

    // failure count after one more failure, saturating
    assign fail_sat = (fail_reg < 3'(MAX_FAILURES)) ? 3'(fail_reg + 3'd1)
                                                    : 3'(MAX_FAILURES);

    // delay picked by the failure count after the increment
    always_comb
    begin
        case (fail_sat)
            3'd0, 3'd1: delay = regs.backoff_first;
            3'd2:       delay = regs.backoff_second;
            3'd3:       delay = regs.backoff_third;
            3'd4:       delay = regs.backoff_fourth;
            default:    delay = regs.backoff_fifth;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        lse_next    = lse_reg | item.link_lost;
        joined_next = joined_reg;
        wait_next   = wait_reg;
        fail_next   = fail_reg;
        nat_next    = nat_reg;

        result.modem_restart = 1'b0;
        result.status_query  = 1'b0;
        result.sleep_request = 1'b0;
        result.sync_request  = 1'b0;
        result.awake_hold    = HOLD_NONE;

        case (phase_reg)
            IDLE:
            begin
                if (due && lse_next)
                begin
                    phase_next        = INIT;
                    result.awake_hold = HOLD_JOIN;
                end
            end
            INIT:
            begin
                joined_next          = 1'b0;
                result.modem_restart = 1'b1;
                wait_next            = 16'd0;
                phase_next           = REG;
            end
            REG:
            begin
                if (item.busy_pin && item.stat_pin)
                begin
                    phase_next = JOINED;
                end
                else if (wait_inc >= regs.timeout)
                begin
                    wait_next         = 16'd0;
                    lse_next          = 1'b1;
                    phase_next        = ERROR;
                    result.awake_hold = HOLD_DEFAULT;
                end
                else
                begin
                    wait_next = wait_inc;
                end
            end
            JOINED:
            begin
                result.status_query = 1'b1;
                joined_next         = 1'b1;
                fail_next           = 3'd0;
                wait_next           = 16'd0;
                phase_next          = IDLE;
                lse_next            = 1'b0;
                result.awake_hold   = HOLD_DEFAULT;
                result.sync_request = 1'b1;
            end
            ERROR:
            begin
                result.awake_hold    = HOLD_DEFAULT;
                phase_next           = IDLE;
                lse_next             = 1'b1;
                result.sleep_request = 1'b1;
                if (due)
                begin
                    fail_next = fail_sat;
                    nat_next  = 32'(item.now_seconds + delay);
                end
            end
            default: ; // codes outside the phase set do nothing
        endcase

        result.phase          = phase_next;
        result.joined_flag    = joined_next;
        result.net_error      = lse_next;
        result.fail_count     = fail_next;
        result.reconnect_time = nat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= IDLE;
            lse_reg    <= 1'b1;
            joined_reg <= 1'b0;
            wait_reg   <= 16'd0;
            fail_reg   <= 3'd0;
            nat_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            lse_reg    <= lse_next;
            joined_reg <= joined_next;
            wait_reg   <= wait_next;
            fail_reg   <= fail_next;
            nat_reg    <= nat_next;
        end
    end

endmodule
